// ===== src/touch_channel_hysteresis_debounce_unit_assert.svh =====
// Assertion macros for the touch channel debounce unit.
// Used by the top level; expects clk and rst_n in scope at the use site.
`ifndef TOUCH_CHANNEL_HYSTERESIS_DEBOUNCE_UNIT_ASSERT_SVH
`define TOUCH_CHANNEL_HYSTERESIS_DEBOUNCE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define TCHD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define TCHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tchd_pkg.sv =====
// Shared types and constants for the touch channel debounce unit.
// No dependencies; imported by all design and testbench modules.
package tchd_pkg;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int CH_W    = 5;
    localparam int VAL_W   = 14;
    localparam int TIME_W  = 32;
    localparam int MASK_W  = 32;
    localparam int DEB_W   = 16;
    localparam int CNT_W   = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;

    // Input word modes
    localparam logic [MODE_W-1:0] MODE_THRESH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SCAN    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS  = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic wr_thresh;   // store threshold of the accepted word
        logic wr_reading;  // store readout of the accepted word
        logic scan_start;  // latch elapsed time, clear event bits
        logic scan_step;   // evaluate the channel at the scan index
        logic load_out;    // move masks into the output register
    } tchd_cmd_t;

endpackage

// ===== src/tchd_ctrl.sv =====
// Controller for the touch channel debounce unit: input handshake,
// scan sequencing and output valid. Depends on tchd_pkg.
module tchd_ctrl #(
    parameter int NUM_CHANNELS = 32,
    parameter int IDX_W = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [tchd_pkg::MODE_W-1:0] in_mode,
    output logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       events_nz,
    output tchd_pkg::tchd_cmd_t        cmd,
    output logic [IDX_W-1:0]           idx
);
    import tchd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             last_idx;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign last_idx = (idx_reg == IDX_W'(NUM_CHANNELS - 1));

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        cmd.wr_thresh  = accept && (in_mode == MODE_THRESH);
        cmd.wr_reading = accept && (in_mode == MODE_READING);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_mode == MODE_SCAN))
                begin
                    cmd.scan_start = 1'b1;
                    idx_next       = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                idx_next      = idx_reg + 1'b1;
                if (last_idx)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // nothing switched: no result
                if (!events_nz)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign idx       = idx_reg;

endmodule

// ===== src/tchd_datapath.sv =====
// Datapath for the touch channel debounce unit: configuration, per-channel
// threshold/readout/counter files and the channel evaluator. Uses tchd_pkg.
module tchd_datapath #(
    parameter int NUM_CHANNELS = 32,
    parameter int IDX_W = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [tchd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tchd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [tchd_pkg::CH_W-1:0]       in_channel,
    input  logic [tchd_pkg::VAL_W-1:0]      in_value,
    input  logic [tchd_pkg::TIME_W-1:0]     in_now_ms,
    input  tchd_pkg::tchd_cmd_t             cmd,
    input  logic [IDX_W-1:0]               idx,
    output logic                           events_nz,
    output logic [tchd_pkg::MASK_W-1:0]     active_bits,
    output logic [tchd_pkg::MASK_W-1:0]     event_bits
);
    import tchd_pkg::*;

    // Configuration registers
    logic [MASK_W-1:0] mask_reg;
    logic [VAL_W-1:0]  hyst_reg;
    logic [DEB_W-1:0]  deb_reg;

    // Channel files
    logic [VAL_W-1:0]        thr_reg [NUM_CHANNELS];
    logic [VAL_W-1:0]        rd_reg  [NUM_CHANNELS];
    logic signed [CNT_W-1:0] cnt_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] act_reg;
    logic [NUM_CHANNELS-1:0] ev_reg;

    // Scan timing
    logic [TIME_W-1:0] last_reg;
    logic              seen_reg;
    logic [DEB_W-1:0]  dt_reg;
    logic [DEB_W-1:0]  dt_next;

    // Output register
    logic [MASK_W-1:0] out_act_reg;
    logic [MASK_W-1:0] out_ev_reg;

    // Evaluator signals
    logic [NUM_CHANNELS-1:0] mask_use;
    logic [VAL_W-1:0]        thr_cur;
    logic [VAL_W-1:0]        rd_cur;
    logic signed [CNT_W-1:0] cnt_cur;
    logic                    act_cur;
    logic                    ch_en;
    logic [VAL_W:0]          trip;
    logic                    up;
    logic                    down;
    logic signed [CNT_W:0]   dt_s;
    logic signed [CNT_W:0]   lim_s;
    logic signed [CNT_W:0]   cnt_ext;
    logic signed [CNT_W:0]   cnt_neg;
    logic signed [CNT_W:0]   sum_up;
    logic signed [CNT_W:0]   sum_dn;
    logic                    sw_up;
    logic                    sw_dn;
    logic signed [CNT_W-1:0] cnt_new;
    logic                    ch_ok;
    logic [IDX_W-1:0]        wr_idx;

    assign mask_use = mask_reg[NUM_CHANNELS-1:0];
    assign ch_ok    = ({1'b0, in_channel} < (CH_W + 1)'(NUM_CHANNELS));
    assign wr_idx   = in_channel[IDX_W-1:0];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            hyst_reg <= '0;
            deb_reg  <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_CHANNEL_MASK: mask_reg <= cfg_wdata;
                CFG_HYSTERESIS:   hyst_reg <= cfg_wdata[VAL_W-1:0];
                CFG_DEBOUNCE_MS:  deb_reg  <= cfg_wdata[DEB_W-1:0];
                default:          ;
            endcase
        end
    end

    // Elapsed time since last scan, modulo 2^16; zero on the first scan
    always_comb
    begin
        dt_next = '0;
        if (seen_reg)
        begin
            dt_next = DEB_W'(in_now_ms - last_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            seen_reg <= 1'b0;
            dt_reg   <= '0;
        end
        else if (cmd.scan_start)
        begin
            last_reg <= in_now_ms;
            seen_reg <= 1'b1;
            dt_reg   <= dt_next;
        end
    end

    // Channel evaluator, one channel per step
    always_comb
    begin
        thr_cur = thr_reg[idx];
        rd_cur  = rd_reg[idx];
        cnt_cur = cnt_reg[idx];
        act_cur = act_reg[idx];
        ch_en   = mask_use[idx] && (thr_cur != '0);
        trip    = {1'b0, thr_cur} + {1'b0, hyst_reg};
        up      = !act_cur && ({1'b0, rd_cur} > trip);
        down    = act_cur && (rd_cur < thr_cur);
        dt_s    = signed'({3'b000, dt_reg});
        lim_s   = signed'({3'b000, deb_reg});
        cnt_ext = (CNT_W + 1)'(cnt_cur);
        // a positive count lapses before counting down
        cnt_neg = (cnt_cur < 0) ? cnt_ext : '0;
        sum_up  = cnt_ext + dt_s;
        sum_dn  = cnt_neg - dt_s;
        sw_up   = up && (sum_up >= lim_s);
        sw_dn   = down && (sum_dn <= -lim_s);
        cnt_new = '0;
        if (up && !sw_up)
        begin
            cnt_new = sum_up[CNT_W-1:0];
        end
        else if (down && !sw_dn)
        begin
            cnt_new = sum_dn[CNT_W-1:0];
        end
    end

    // Threshold and readout files, counters, active and event flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                thr_reg[i] <= '0;
                rd_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
            act_reg <= '0;
            ev_reg  <= '0;
        end
        else
        begin
            if (cmd.wr_thresh && ch_ok)
            begin
                thr_reg[wr_idx] <= in_value;
            end
            if (cmd.wr_reading && ch_ok)
            begin
                rd_reg[wr_idx] <= in_value;
            end
            if (cmd.scan_start)
            begin
                ev_reg <= '0;
            end
            if (cmd.scan_step && ch_en)
            begin
                cnt_reg[idx] <= cnt_new;
                if (sw_up || sw_dn)
                begin
                    act_reg[idx] <= sw_up;
                    ev_reg[idx]  <= 1'b1;
                end
            end
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_act_reg <= MASK_W'(act_reg);
            out_ev_reg  <= MASK_W'(ev_reg);
        end
    end

    assign events_nz   = |ev_reg;
    assign active_bits = out_act_reg;
    assign event_bits  = out_ev_reg;

endmodule

// ===== src/touch_channel_hysteresis_debounce_unit.sv =====
// Touch channel debounce unit: top level joining controller and datapath.
// Depends on tchd_pkg, tchd_ctrl, tchd_datapath and the assertion header.
//
// Qualifies up to NUM_CHANNELS capacitive touch channels with hysteresis and
// a millisecond debounce. Threshold (mode 0), readout (mode 1) and ignored
// (mode 3) words are taken while idle. An end-of-scan word (mode 2) holds
// s_tready low while the single channel evaluator updates one channel per
// cycle and a final state decides the result. A result word is produced only
// when some channel switched; it sits in an output register, so input words
// keep flowing while it waits, and a later scan with a result holds in its
// final state until the register frees. The user must write configuration via
// cfg_wen/cfg_index/cfg_wdata only while idle; the block does not enforce it.
module touch_channel_hysteresis_debounce_unit #(
    parameter int NUM_CHANNELS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Config: 0 channel_mask, 1 hysteresis, 2 debounce_ms
    input  logic                            cfg_wen,
    input  logic [tchd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tchd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: mode[1:0], channel[6:2], value[20:7], now_ms[52:21], zero fill
    input  logic [tchd_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: active_bits[31:0], event_bits[63:32]
    output logic [tchd_pkg::OUT_DATA_W-1:0] m_tdata
);
    import tchd_pkg::*;

    `include "touch_channel_hysteresis_debounce_unit_assert.svh"

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [MODE_W-1:0] in_mode;
    logic [CH_W-1:0]   in_channel;
    logic [VAL_W-1:0]  in_value;
    logic [TIME_W-1:0] in_now_ms;
    tchd_cmd_t         cmd;
    logic [IDX_W-1:0]  idx;
    logic              events_nz;
    logic [MASK_W-1:0] active_bits;
    logic [MASK_W-1:0] event_bits;

    // Unpack input word
    assign in_mode    = s_tdata[1:0];
    assign in_channel = s_tdata[6:2];
    assign in_value   = s_tdata[20:7];
    assign in_now_ms  = s_tdata[52:21];

    tchd_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (in_mode),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .events_nz (events_nz),
        .cmd       (cmd),
        .idx       (idx)
    );

    tchd_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_channel  (in_channel),
        .in_value    (in_value),
        .in_now_ms   (in_now_ms),
        .cmd         (cmd),
        .idx         (idx),
        .events_nz   (events_nz),
        .active_bits (active_bits),
        .event_bits  (event_bits)
    );

    assign m_tdata = {event_bits, active_bits};

    // Checks
    `TCHD_ASSERT_NOW(a_no_accept_in_scan, cmd.scan_step, !s_tready, "word accepted during scan")
    `TCHD_ASSERT_NOW(a_no_overwrite, cmd.load_out, (!m_tvalid || m_tready), "pending result lost")
    `TCHD_ASSERT_NEXT(a_load_valid, cmd.load_out, m_tvalid, "loaded result not presented")
    `TCHD_ASSERT_NOW(a_result_has_event, m_tvalid, (m_tdata[63:32] != '0), "result without event")

endmodule

// ===== tb/sv/touch_scan_checker.sv =====
`timescale 1ns / 1ps
// Checker for the touch channel debounce unit. It keeps its own copy of the
// channel state, predicts each scan report and compares the m-side words.
// Depends on tchd_pkg for widths, modes and register indexes.
module touch_scan_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [tchd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tchd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // s_tdata: mode, channel, value, now_ms, zero fill
    input  logic [tchd_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: active_bits, event_bits
    input  logic [tchd_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                              fail_count,
    output int                              pending
);
    import tchd_pkg::*;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [VAL_W-1:0]  value;
        logic [CH_W-1:0]   channel;
        logic [MODE_W-1:0] mode;
    } touch_word_t;

    typedef struct packed {
        logic [MASK_W-1:0] event_bits;
        logic [MASK_W-1:0] active_bits;
    } scan_report_t;

    // Register copies
    logic [MASK_W-1:0] chan_mask;
    logic [VAL_W-1:0]  hyst_margin;
    logic [DEB_W-1:0]  debounce_limit;

    // Channel state
    logic [VAL_W-1:0]        thresholds [32];
    logic [VAL_W-1:0]        readouts [32];
    logic signed [CNT_W-1:0] hold_counts [32];
    logic [MASK_W-1:0]       active_flags;
    logic [TIME_W-1:0]       last_scan_ms;
    bit                      scanned;

    scan_report_t expected_reports [$];

    // One end-of-scan pass over all channels; returns the switched channels
    function automatic logic [MASK_W-1:0] evaluate_scan(input logic [TIME_W-1:0] now_ms);
        logic [TIME_W-1:0] delta;
        logic [MASK_W-1:0] switched;
        int                elapsed;
        int                limit;
        int                count;
        bit                rising;
        bit                falling;
        delta    = now_ms - last_scan_ms;
        elapsed  = scanned ? int'(delta[15:0]) : 0;
        limit    = int'(debounce_limit);
        switched = '0;
        for (int ch = 0; ch < 32; ch++)
        begin
            // absent or disabled channels keep counter and flag
            if (!chan_mask[ch] || thresholds[ch] == '0)
                continue;
            rising  = !active_flags[ch] &&
                      (int'(readouts[ch]) > int'(thresholds[ch]) + int'(hyst_margin));
            falling = active_flags[ch] && (readouts[ch] < thresholds[ch]);
            count   = int'(hold_counts[ch]);

            if (rising)
            begin
                count += elapsed;
                if (count >= limit)
                begin
                    active_flags[ch] = 1'b1;
                    count            = 0;
                    switched[ch]     = 1'b1;
                end
            end
            else if (count > 0)
                count = 0;

            if (falling)
            begin
                count -= elapsed;
                if (count <= -limit)
                begin
                    active_flags[ch] = 1'b0;
                    count            = 0;
                    switched[ch]     = 1'b1;
                end
            end
            else if (count < 0)
                count = 0;

            hold_counts[ch] = count[CNT_W-1:0];
        end
        last_scan_ms = now_ms;
        scanned      = 1'b1;
        return switched;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        touch_word_t       word_in;
        scan_report_t      got;
        scan_report_t      want;
        logic [MASK_W-1:0] switched;
        if (!rst_n)
        begin
            chan_mask      = '0;
            hyst_margin    = '0;
            debounce_limit = '0;
            for (int ch = 0; ch < 32; ch++)
            begin
                thresholds[ch]  = '0;
                readouts[ch]    = '0;
                hold_counts[ch] = '0;
            end
            active_flags = '0;
            last_scan_ms = '0;
            scanned      = 1'b0;
            expected_reports.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // report words first: they always stem from an earlier scan
            if (m_tvalid && m_tready)
            begin
                got = scan_report_t'(m_tdata);
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: report word with none expected: expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.active_bits !== want.active_bits)
                    begin
                        fail_count++;
                        $display("%0t: active_bits mismatch: expected %h, actual %h",
                                 $time, want.active_bits, got.active_bits);
                    end
                    if (got.event_bits !== want.event_bits)
                    begin
                        fail_count++;
                        $display("%0t: event_bits mismatch: expected %h, actual %h",
                                 $time, want.event_bits, got.event_bits);
                    end
                end
            end

            // register writes
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_CHANNEL_MASK: chan_mask      = cfg_wdata[MASK_W-1:0];
                    CFG_HYSTERESIS:   hyst_margin    = cfg_wdata[VAL_W-1:0];
                    CFG_DEBOUNCE_MS:  debounce_limit = cfg_wdata[DEB_W-1:0];
                    default: ;
                endcase
            end

            // input words
            if (s_tvalid && s_tready)
            begin
                word_in = touch_word_t'(s_tdata[$bits(touch_word_t)-1:0]);
                case (word_in.mode)
                    MODE_THRESH:  thresholds[word_in.channel] = word_in.value;
                    MODE_READING: readouts[word_in.channel]   = word_in.value;
                    MODE_SCAN:
                    begin
                        switched = evaluate_scan(word_in.now_ms);
                        if (switched != '0)
                            expected_reports.push_back(scan_report_t'{event_bits: switched,
                                                       active_bits: active_flags});
                    end
                    default: ;
                endcase
            end
            pending = expected_reports.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for the touch channel debounce unit: clock, reset, stimulus
// and verdict. Depends on tchd_pkg, the unit and touch_scan_checker.
module testbench;
    import tchd_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES     = 72;
    localparam int STALL_LIMIT       = 4000;
    localparam int ITEMS_PER_SETTING = 140;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata: mode[1:0], channel[6:2], value[20:7], now_ms[52:21], zero fill
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata: active_bits[31:0], event_bits[63:32]
    logic [OUT_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int snd_idle_pct;
    int rcv_idle_pct;
    int stall_cycles;
    int words_sent;

    // Stimulus-side view, used only to aim readouts near the switch points
    logic [VAL_W-1:0]  thresh_plan [32];
    logic [VAL_W-1:0]  hyst_now;
    logic [DEB_W-1:0]  deb_now;
    logic [TIME_W-1:0] clock_ms;

    touch_channel_hysteresis_debounce_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    touch_scan_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Report side backpressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Watchdog on cycles without any accepted word or register write
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Offer one word, with random idle cycles ahead of it; ends on a falling edge
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [CH_W-1:0] channel,
                             input logic [VAL_W-1:0] value, input logic [TIME_W-1:0] now_ms);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({now_ms, value, channel, mode});
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        if (mode == MODE_THRESH)
            thresh_plan[channel] = value;
        if (mode != MODE_UNUSED)
            words_sent++;
    endtask

    // Wait for the unit to drain, then write all three registers
    task automatic configure(input logic [MASK_W-1:0] mask, input logic [VAL_W-1:0] hyst,
                             input logic [DEB_W-1:0] deb);
        s_tvalid <= 1'b0;
        while (pending != 0 || !s_tready)
            @(negedge clk);
        // a scan without a report may still be finishing
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_CHANNEL_MASK;
        cfg_wdata <= CFG_DATA_W'(mask);
        @(negedge clk);
        cfg_index <= CFG_HYSTERESIS;
        cfg_wdata <= CFG_DATA_W'(hyst);
        @(negedge clk);
        cfg_index <= CFG_DEBOUNCE_MS;
        cfg_wdata <= CFG_DATA_W'(deb);
        @(negedge clk);
        cfg_wen    <= 1'b0;
        hyst_now   = hyst;
        deb_now    = deb;
        words_sent = 0;
    endtask

    initial
    begin
        int                r;
        int                v;
        int                sel;
        logic [CH_W-1:0]   ch;
        logic [MASK_W-1:0] mask;
        logic [VAL_W-1:0]  hyst;
        logic [DEB_W-1:0]  deb;

        rst_n        = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        snd_idle_pct = 25;
        rcv_idle_pct = 72;
        words_sent   = 0;
        hyst_now     = '0;
        deb_now      = '0;
        for (int i = 0; i < 32; i++)
            thresh_plan[i] = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero debounce, zero hysteresis, every channel present
        configure(32'hFFFF_FFFF, '0, '0);
        send_word(MODE_THRESH, 5'd0, 14'd100, $urandom);
        send_word(MODE_THRESH, 5'd31, 14'h3FFF, $urandom);
        send_word(MODE_THRESH, 5'd7, 14'd1, $urandom);
        send_word(MODE_READING, 5'd0, 14'd101, $urandom);
        send_word(MODE_READING, 5'd31, 14'h3FFF, $urandom);
        send_word(MODE_READING, 5'd7, 14'd0, $urandom);
        // unknown mode, every field at its top
        send_word(MODE_UNUSED, 5'd31, 14'h3FFF, 32'hFFFF_FFFF);
        // first scan: no elapsed time, yet zero debounce switches at once
        send_word(MODE_SCAN, 5'd0, 14'd0, 32'hFFFF_FFF0);
        send_word(MODE_READING, 5'd0, 14'd99, 32'd0);
        // time wraps through zero
        send_word(MODE_SCAN, 5'd31, 14'h3FFF, 32'h0000_0010);
        // zero threshold disables the channel whatever its readout
        send_word(MODE_THRESH, 5'd0, 14'd0, 32'd0);
        send_word(MODE_READING, 5'd0, 14'h3FFF, 32'd0);
        send_word(MODE_SCAN, 5'd0, 14'd0, 32'h0000_0020);

        // Full hysteresis and debounce, only the outer channels present
        configure(32'h8000_0001, 14'h3FFF, 16'hFFFF);
        send_word(MODE_THRESH, 5'd0, 14'd1, 32'd0);
        // elapsed of exactly 2^16 folds to zero
        send_word(MODE_SCAN, 5'd0, 14'd0, 32'h0001_0020);

        // 10 ms debounce with a lapse in the middle
        configure(32'hFFFF_FFFF, 14'd5, 16'd10);
        send_word(MODE_THRESH, 5'd3, 14'd1000, 32'd0);
        send_word(MODE_READING, 5'd3, 14'd1006, 32'd0);
        send_word(MODE_SCAN, 5'd0, 14'd0, 32'h0001_0024);
        send_word(MODE_READING, 5'd3, 14'd1005, 32'd0);
        send_word(MODE_SCAN, 5'd0, 14'd0, 32'h0001_0028);
        send_word(MODE_READING, 5'd3, 14'd1006, 32'd0);
        send_word(MODE_SCAN, 5'd0, 14'd0, 32'h0001_0031);
        send_word(MODE_SCAN, 5'd0, 14'd0, 32'h0001_0032);
        send_word(MODE_SCAN, 5'd0, 14'd0, 32'h0002_0031);

        // Random scan frames, three idle profiles, four settings each
        clock_ms = $urandom;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    snd_idle_pct = 25;
                    rcv_idle_pct = 72;
                end
                1:
                begin
                    snd_idle_pct = 72;
                    rcv_idle_pct = 25;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < 4; k++)
            begin
                sel = phase * 4 + k;
                case (sel)
                    0:
                    begin
                        mask = 32'hFFFF_FFFF; hyst = '0; deb = '0;
                    end
                    1:
                    begin
                        mask = '0;
                        hyst = VAL_W'($urandom_range(16383));
                        deb  = DEB_W'($urandom_range(65535));
                    end
                    4:
                    begin
                        mask = 32'hFFFF_FFFF; hyst = 14'h3FFF; deb = 16'hFFFF;
                    end
                    default:
                    begin
                        mask = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
                        hyst = VAL_W'($urandom_range(40));
                        deb  = DEB_W'($urandom_range(30));
                    end
                endcase
                configure(mask, hyst, deb);

                if (sel == 0)
                    for (int i = 0; i < 32; i++)
                        send_word(MODE_THRESH, i[CH_W-1:0], VAL_W'($urandom_range(1, 3000)),
                                  $urandom);

                while (words_sent < ITEMS_PER_SETTING)
                begin
                    // occasional threshold change, zero and top value among them
                    if ($urandom_range(3) == 0)
                    begin
                        r = $urandom_range(99);
                        v = (r < 8) ? 0 : (r < 12) ? 16383 : int'($urandom_range(1, 3000));
                        send_word(MODE_THRESH, CH_W'($urandom_range(31)), v[VAL_W-1:0],
                                  $urandom);
                    end

                    // readouts aimed at the rise and fall points, some at random
                    repeat ($urandom_range(1, 6))
                    begin
                        ch = CH_W'($urandom_range(31));
                        r  = $urandom_range(9);
                        if (r == 0)
                            v = $urandom_range(16383);
                        else if (r < 6)
                            v = int'(thresh_plan[ch]) + int'(hyst_now)
                                + int'($urandom_range(6)) - 2;
                        else
                            v = int'(thresh_plan[ch]) + int'($urandom_range(4)) - 3;
                        if (v < 0)
                            v = 0;
                        if (v > 16383)
                            v = 16383;
                        send_word(MODE_READING, ch, v[VAL_W-1:0], $urandom);
                    end

                    if ($urandom_range(19) == 0)
                        send_word(MODE_UNUSED, CH_W'($urandom_range(31)),
                                  VAL_W'($urandom_range(16383)), $urandom);

                    // advance time: mostly near the debounce, sometimes jumps
                    r = $urandom_range(19);
                    if (r == 0)
                        clock_ms = $urandom;
                    else if (r == 1)
                        clock_ms += 32'hFFFF;
                    else if (r != 2)
                        clock_ms += (deb_now > 1000) ? $urandom_range(65535)
                                                     : $urandom_range(int'(deb_now) / 2 + 3);
                    send_word(MODE_SCAN, CH_W'($urandom_range(31)),
                              VAL_W'($urandom_range(16383)), clock_ms);
                end
            end
        end

        // Drain and verdict
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/tchd_pkg.sv
src/tchd_ctrl.sv
src/tchd_datapath.sv
src/touch_channel_hysteresis_debounce_unit.sv
tb/sv/touch_scan_checker.sv
tb/sv/testbench.sv
